@@ src/jxsq_pkg.sv @@
package jxsq_pkg;

    localparam int unsigned LANES    = 4;
    localparam int unsigned COEFF_W  = 16;
    localparam int unsigned MAG_W    = 15;
    localparam int unsigned GCLI_W   = 4;
    localparam int unsigned TRUNC_W  = 4;
    localparam int unsigned LCNT_W   = 3;
    localparam int unsigned SHAMT_W  = 5;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned WIDE_W   = 48;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 72;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRUNC     = 1'd1;

    localparam logic QMODE_UNIFORM  = 1'b0;
    localparam logic QMODE_DEADZONE = 1'b1;

    localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;

endpackage

@@ src/jpeg_xs_coefficient_quantizer.sv @@
// Deadzone / uniform quantizer for groups of four sign-magnitude wavelet coefficients.
// One word enters per clock unless stalled; the three stages are the scaling shift and
// subtract, the rounding add and right shift, and the truncation shift with saturation and
// sign handling. A stall on the output holds the whole pipeline, so s_tready follows m_tready
// while the last stage is full. The user must write quant_mode and truncation_level through
// the cfg port only while no word is in flight (unenforced); each word samples both on entry.
module jpeg_xs_coefficient_quantizer #(
    parameter int GROUP_LANES = 4
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,

    input  logic                                      cfg_we,
    input  logic [jxsq_pkg::CFG_IDX_W-1:0]            cfg_addr,
    input  logic [jxsq_pkg::CFG_DATA_W-1:0]           cfg_wdata,

    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // From bit 0: coeff_0, coeff_1, coeff_2, coeff_3, group_gcli, lanes_valid, zero pad.
    input  logic [jxsq_pkg::S_TDATA_W-1:0]            s_tdata,

    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // From bit 0: q_0, q_1, q_2, q_3, lanes_valid_out, zero pad.
    output logic [jxsq_pkg::M_TDATA_W-1:0]            m_tdata
);

    localparam int unsigned L  = jxsq_pkg::LANES;
    localparam int unsigned CW = jxsq_pkg::COEFF_W;
    localparam int unsigned MW = jxsq_pkg::MAG_W;
    localparam int unsigned AW = jxsq_pkg::ACC_W;
    localparam int unsigned WW = jxsq_pkg::WIDE_W;
    localparam int unsigned GW = jxsq_pkg::GCLI_W;
    localparam int unsigned TW = jxsq_pkg::TRUNC_W;
    localparam int unsigned NW = jxsq_pkg::LCNT_W;
    localparam int unsigned SW = jxsq_pkg::SHAMT_W;

    logic          mode_reg;
    logic [TW-1:0] trunc_reg;

    logic advance;

    logic          v1_reg, v2_reg, v3_reg;
    logic          mode1_reg, mode2_reg;
    logic [TW-1:0] trunc1_reg, trunc2_reg;
    logic [GW-1:0] gcli1_reg;
    logic          zero1_reg, zero2_reg;
    logic [L-1:0]  en1_reg, en2_reg;
    logic [NW-1:0] lv1_reg, lv2_reg, lv3_reg;
    logic [L-1:0]  sign1_reg, sign2_reg;
    logic [MW-1:0] mag1_reg [L];
    logic [MW-1:0] mag2_reg [L];
    logic [AW-1:0] a1_reg   [L];
    logic [AW-1:0] d2_reg   [L];
    logic [CW-1:0] q3_reg   [L];

    logic [AW-1:0] a1_next  [L];
    logic [AW-1:0] d2_next  [L];
    logic [CW-1:0] q3_next  [L];
    logic [L-1:0]  en1_next;
    logic [SW-1:0] s_amt;
    logic [SW-1:0] r_amt;
    logic [GW-1:0] in_gcli;
    logic [NW-1:0] in_lv;
    logic [MW-1:0] keep_mask;

    assign advance  = !v3_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = v3_reg;

    assign in_gcli = s_tdata[L*CW +: GW];
    assign in_lv   = s_tdata[L*CW+GW +: NW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= jxsq_pkg::QMODE_UNIFORM;
            trunc_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                jxsq_pkg::CFG_QUANT_MODE: mode_reg  <= cfg_wdata[0];
                jxsq_pkg::CFG_TRUNC:      trunc_reg <= cfg_wdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: m * (2^s - 1) with s = gcli - trunc + 1.
    always_comb begin
        logic [AW-1:0] m_ext;
        s_amt = {1'b0, in_gcli} - {1'b0, trunc_reg} + SW'(1);
        for (int i = 0; i < L; i++) begin
            m_ext      = AW'(s_tdata[i*CW +: MW]);
            a1_next[i] = (m_ext << s_amt) - m_ext;
            en1_next[i] = ({1'b0, in_lv} > (NW+1)'(i)) && (i < GROUP_LANES);
        end
    end

    // Stage 2: add 2^gcli and drop gcli + 1 bits.
    always_comb begin
        r_amt = {1'b0, gcli1_reg} + SW'(1);
        for (int i = 0; i < L; i++) begin
            d2_next[i] = (a1_reg[i] + (AW'(1) << gcli1_reg)) >> r_amt;
        end
    end

    // Stage 3: uniform restores truncated planes, saturates; deadzone clears them; mask, sign
    always_comb begin
        logic [WW-1:0] e;
        logic [MW-1:0] uni;
        logic [MW-1:0] qm;
        keep_mask = jxsq_pkg::MAG_MAX << trunc2_reg;
        for (int i = 0; i < L; i++) begin
            e   = WW'(d2_reg[i]) << trunc2_reg;
            uni = (e > WW'(jxsq_pkg::MAG_MAX)) ? jxsq_pkg::MAG_MAX : e[MW-1:0];
            if (mode2_reg == jxsq_pkg::QMODE_DEADZONE) begin
                qm = mag2_reg[i] & keep_mask;
            end else begin
                qm = zero2_reg ? '0 : uni;
            end
            if (en2_reg[i] && (qm != '0)) begin
                q3_next[i] = {sign2_reg[i], qm};
            end else begin
                q3_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mode1_reg  <= mode_reg;
            trunc1_reg <= trunc_reg;
            gcli1_reg  <= in_gcli;
            zero1_reg  <= (in_gcli <= trunc_reg);
            en1_reg    <= en1_next;
            lv1_reg    <= in_lv;
            for (int i = 0; i < L; i++) begin
                sign1_reg[i] <= s_tdata[i*CW + MW];
                mag1_reg[i]  <= s_tdata[i*CW +: MW];
                a1_reg[i]    <= a1_next[i];
            end

            mode2_reg  <= mode1_reg;
            trunc2_reg <= trunc1_reg;
            zero2_reg  <= zero1_reg;
            en2_reg    <= en1_reg;
            lv2_reg    <= lv1_reg;
            sign2_reg  <= sign1_reg;
            for (int i = 0; i < L; i++) begin
                mag2_reg[i] <= mag1_reg[i];
                d2_reg[i]   <= d2_next[i];
            end

            lv3_reg <= lv2_reg;
            for (int i = 0; i < L; i++) begin
                q3_reg[i] <= q3_next[i];
            end
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < L; i++) begin
            m_tdata[i*CW +: CW] = q3_reg[i];
        end
        m_tdata[L*CW +: NW] = lv3_reg;
    end

endmodule

@@ src/jxsq_checker.sv @@
module jxsq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [jxsq_pkg::M_TDATA_W-1:0]     m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled output word changed.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_no_block: assert property (@(posedge aclk)
        m_tready |-> s_tready)
        else $error("Input blocked while output is taken.");

    a_no_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[66:64] == 3'd0) |-> (m_tdata[63:0] == 64'd0))
        else $error("Nonzero lane with no valid lanes.");

    a_no_neg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !((m_tdata[15] && (m_tdata[14:0] == 15'd0))
                    || (m_tdata[31] && (m_tdata[30:16] == 15'd0))
                    || (m_tdata[47] && (m_tdata[46:32] == 15'd0))
                    || (m_tdata[63] && (m_tdata[62:48] == 15'd0))))
        else $error("Sign set on a zero magnitude.");

endmodule

bind jpeg_xs_coefficient_quantizer jxsq_checker u_jxsq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/jpeg_xs_coefficient_quantizer_tb.sv @@
module jpeg_xs_coefficient_quantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUP_LANES    = 4;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SWEEP_WORDS    = 130;

    typedef struct packed {
        logic [jxsq_pkg::LCNT_W-1:0]                      lanes;
        logic [jxsq_pkg::GCLI_W-1:0]                      gcli;
        logic [jxsq_pkg::LANES-1:0][jxsq_pkg::COEFF_W-1:0] coeff;
    } quant_group_t;

    typedef struct packed {
        logic [jxsq_pkg::LCNT_W-1:0]                      lanes;
        logic [jxsq_pkg::LANES-1:0][jxsq_pkg::COEFF_W-1:0] q;
    } quant_word_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [jxsq_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [jxsq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [jxsq_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [jxsq_pkg::M_TDATA_W-1:0]  m_tdata;

    logic                         qmode_shadow = jxsq_pkg::QMODE_UNIFORM;
    logic [jxsq_pkg::TRUNC_W-1:0] trunc_shadow = '0;

    quant_word_t pending_quant[$];

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit stall_long   = 1'b0;

    int error_count    = 0;
    int checked_words  = 0;
    int uniform_words  = 0;
    int deadzone_words = 0;
    int configs_used   = 0;
    int idle_cycles    = 0;

    jpeg_xs_coefficient_quantizer #(
        .GROUP_LANES(GROUP_LANES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [jxsq_pkg::COEFF_W-1:0] quantize_lane(
            logic [jxsq_pkg::COEFF_W-1:0] c, logic [jxsq_pkg::GCLI_W-1:0] gcli);
        logic [jxsq_pkg::MAG_W-1:0] mag;
        logic [63:0]                d;
        logic [5:0]                 up;
        mag = c[jxsq_pkg::MAG_W-1:0];
        if (qmode_shadow == jxsq_pkg::QMODE_DEADZONE) begin
            d = 64'(mag & (jxsq_pkg::MAG_MAX << trunc_shadow));
        end else if (gcli <= trunc_shadow) begin
            d = '0;
        end else begin
            up = 6'(gcli) - 6'(trunc_shadow) + 6'd1;
            d = ((64'(mag) << up) - 64'(mag) + (64'd1 << gcli)) >> (6'(gcli) + 6'd1);
            d = d << trunc_shadow;
            if (d > 64'(jxsq_pkg::MAG_MAX)) begin
                d = 64'(jxsq_pkg::MAG_MAX);
            end
        end
        if (d == '0) begin
            return '0;
        end
        return {c[jxsq_pkg::COEFF_W-1], d[jxsq_pkg::MAG_W-1:0]};
    endfunction

    function automatic quant_word_t quantize_group(quant_group_t g);
        quant_word_t w;
        w.lanes = g.lanes;
        for (int i = 0; i < jxsq_pkg::LANES; i++) begin
            if (i < g.lanes && i < GROUP_LANES) begin
                w.q[i] = quantize_lane(g.coeff[i], g.gcli);
            end else begin
                w.q[i] = '0;
            end
        end
        return w;
    endfunction

    // Most coefficients keep their magnitudes within the bit-plane count, as the encoder produces them.
    function automatic quant_group_t random_group();
        quant_group_t               g;
        logic [jxsq_pkg::MAG_W-1:0] fit;
        g.gcli = jxsq_pkg::GCLI_W'($urandom_range(0, 15));
        if ($urandom_range(0, 6) == 0) begin
            g.lanes = jxsq_pkg::LCNT_W'($urandom_range(0, 7));
        end else if ($urandom_range(0, 3) == 0) begin
            g.lanes = jxsq_pkg::LCNT_W'($urandom_range(1, 3));
        end else begin
            g.lanes = jxsq_pkg::LCNT_W'(4);
        end
        fit = jxsq_pkg::MAG_W'((32'd1 << g.gcli) - 32'd1);
        for (int i = 0; i < jxsq_pkg::LANES; i++) begin
            g.coeff[i] = jxsq_pkg::COEFF_W'($urandom);
            if ($urandom_range(0, 4) != 0) begin
                g.coeff[i][jxsq_pkg::MAG_W-1:0] &= fit;
            end
        end
        return g;
    endfunction

    task automatic set_config(input logic mode, input logic [jxsq_pkg::TRUNC_W-1:0] trunc);
        cfg_we    <= 1'b1;
        cfg_addr  <= jxsq_pkg::CFG_QUANT_MODE;
        cfg_wdata <= jxsq_pkg::CFG_DATA_W'(mode);
        @(posedge aclk);
        qmode_shadow = mode;
        cfg_addr  <= jxsq_pkg::CFG_TRUNC;
        cfg_wdata <= jxsq_pkg::CFG_DATA_W'(trunc);
        @(posedge aclk);
        trunc_shadow = trunc;
        cfg_we <= 1'b0;
        configs_used++;
    endtask

    task automatic send_group(input quant_group_t g);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= jxsq_pkg::S_TDATA_W'(g);
        do @(posedge aclk); while (!s_tready);
        pending_quant.push_back(quantize_group(g));
        if (qmode_shadow == jxsq_pkg::QMODE_DEADZONE) begin
            deadzone_words++;
        end else begin
            uniform_words++;
        end
    endtask

    task automatic send_coeffs(input logic [15:0] c0, input logic [15:0] c1,
                               input logic [15:0] c2, input logic [15:0] c3,
                               input logic [jxsq_pkg::GCLI_W-1:0] gcli,
                               input logic [jxsq_pkg::LCNT_W-1:0] lanes);
        quant_group_t g;
        g.coeff = {c3, c2, c1, c0};
        g.gcli  = gcli;
        g.lanes = lanes;
        send_group(g);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_quant.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] want_v,
                                   input logic [15:0] got_v);
        error_count++;
        if (error_count <= 10) begin
            $display("Mismatch on %s: expected %h, got %h", field, want_v, got_v);
        end
    endtask

    // Uniform mode with no truncation is what the block comes out of reset with.
    task automatic test_reset_defaults();
        send_coeffs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0, 3'd4);
        send_coeffs(16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 4'd15, 3'd4);
        send_coeffs(16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 4'd0, 3'd4);
        send_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 3'd0);
        send_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 3'd7);
        send_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 3'd5);
        send_coeffs(16'h8003, 16'h0005, 16'hFFFF, 16'h1234, 4'd2, 3'd1);
        wait_until_drained();
    endtask

    task automatic test_directed_cases();
        set_config(jxsq_pkg::QMODE_UNIFORM, 4'd15);
        send_coeffs(16'hFFFF, 16'h7FFF, 16'h8001, 16'h0001, 4'd15, 3'd4);
        wait_until_drained();
        set_config(jxsq_pkg::QMODE_UNIFORM, 4'd7);
        send_coeffs(16'h80FF, 16'h00FF, 16'hFFFF, 16'h8001, 4'd8, 3'd4);
        send_coeffs(16'h8080, 16'h0040, 16'h807F, 16'h7FFF, 4'd7, 3'd3);
        wait_until_drained();
        set_config(jxsq_pkg::QMODE_DEADZONE, 4'd0);
        send_coeffs(16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 4'd0, 3'd4);
        send_coeffs(16'h8000, 16'h0000, 16'hFFFF, 16'h8001, 4'd9, 3'd2);
        wait_until_drained();
        set_config(jxsq_pkg::QMODE_DEADZONE, 4'd15);
        send_coeffs(16'hFFFF, 16'h7FFF, 16'h8001, 16'h4000, 4'd0, 3'd4);
        wait_until_drained();
        set_config(jxsq_pkg::QMODE_DEADZONE, 4'd4);
        send_coeffs(16'h800F, 16'h8010, 16'h000F, 16'hFFF0, 4'd3, 3'd4);
        send_coeffs(16'hFFFF, 16'h0010, 16'h800F, 16'h7FFF, 4'd15, 3'd6);
        wait_until_drained();
    endtask

    task automatic test_random_sweep();
        logic                         mode;
        logic [jxsq_pkg::TRUNC_W-1:0] trunc;
        for (int p = 0; p < 10; p++) begin
            if (p < 4) begin
                mode  = (p < 2) ? jxsq_pkg::QMODE_UNIFORM : jxsq_pkg::QMODE_DEADZONE;
                trunc = (p % 2 == 1) ? 4'd15 : 4'd0;
            end else begin
                mode  = ($urandom_range(0, 1) == 1) ? jxsq_pkg::QMODE_DEADZONE
                                                    : jxsq_pkg::QMODE_UNIFORM;
                trunc = jxsq_pkg::TRUNC_W'($urandom_range(0, 15));
            end
            set_config(mode, trunc);
            repeat (SWEEP_WORDS) send_group(random_group());
            wait_until_drained();
        end
    endtask

    // The output is held off long enough for the pipeline to fill and push back on the input.
    task automatic test_output_stall();
        src_idle_en = 1'b0;
        set_config(jxsq_pkg::QMODE_UNIFORM, jxsq_pkg::TRUNC_W'($urandom_range(0, 6)));
        stall_long = 1'b1;
        repeat (20) send_group(random_group());
        wait_until_drained();
        repeat (20) send_group(random_group());
        wait_until_drained();
        src_idle_en = 1'b1;
    endtask

    task automatic test_steady_stream();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        set_config(jxsq_pkg::QMODE_DEADZONE, jxsq_pkg::TRUNC_W'($urandom_range(1, 14)));
        repeat (50) send_group(random_group());
        wait_until_drained();
        set_config(jxsq_pkg::QMODE_UNIFORM, jxsq_pkg::TRUNC_W'($urandom_range(1, 14)));
        repeat (50) send_group(random_group());
        wait_until_drained();
    endtask

    initial begin
        forever begin
            if (stall_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                stall_long = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        quant_word_t want;
        quant_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(quant_word_t)-1:0];
            if (pending_quant.size() == 0) begin
                report_mismatch("unexpected word q_0", 16'h0, got.q[0]);
            end else begin
                want = pending_quant.pop_front();
                checked_words++;
                for (int i = 0; i < jxsq_pkg::LANES; i++) begin
                    if (got.q[i] !== want.q[i]) begin
                        report_mismatch($sformatf("q_%0d", i), want.q[i], got.q[i]);
                    end
                end
                if (got.lanes !== want.lanes) begin
                    report_mismatch("lanes_valid_out", 16'(want.lanes), 16'(got.lanes));
                end
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL jpeg_xs_coefficient_quantizer");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_cases();
        test_random_sweep();
        test_output_stall();
        test_steady_stream();
        $display("Checked %0d result words over %0d register settings after reset.",
                 checked_words, configs_used);
        $display("Uniform mode saw %0d groups and deadzone mode %0d, with output stalls.",
                 uniform_words, deadzone_words);
        if (error_count == 0 && pending_quant.size() == 0) begin
            $display("PASS jpeg_xs_coefficient_quantizer");
        end else begin
            $display("FAIL jpeg_xs_coefficient_quantizer");
        end
        $finish;
    end

endmodule
